// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum filter.
`default_nettype none

package swm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CFG_W    = 7;
  // Ages and fill counts never exceed the largest programmable window.
  localparam int unsigned AGE_W    = CFG_W;

  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(3);

  // Contents of one queue cell.
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] val;
    logic [AGE_W-1:0]           age;
  } swm_cell_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                       step;
    logic                       clear;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] sample;
  } swm_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swm_if.sv =====
// Valid/ready channel interfaces for samples and results.
`default_nettype none

interface swm_in_if import swm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sliding_window_max_filter.sv =====
// Sliding window maximum filter: a chain of queue cells plus window control.
// The result for a sample is shown in the cycle after its beat is accepted.
// Throughput: one sample per cycle while the result side keeps taking beats; the
//   cell chain updates every candidate in the same cycle with a one-neighbor hop.
// Reset: empties the candidate queue and fill count, window size returns to 3.
// A window size write also empties the queue and restarts the fill count.
`default_nettype none

module sliding_window_max_filter import swm_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  swm_in_if.sink                in_i,
  swm_out_if.source             out_o
);

  localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] WIN_CLIP =
    (WINDOW_MAX > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(WINDOW_MAX);

  logic [CFG_W-1:0]           win_q;
  logic [CFG_W-1:0]           win_eff;
  logic [AGE_W-1:0]           fill_q, fill_base, fill_d;
  logic                       res_vld_q;
  logic signed [SAMPLE_W-1:0] res_q;
  logic                       step;
  logic                       emit;
  swm_ctrl_t                  ctrl;

  swm_cell_t                  cell_st  [WINDOW_MAX];
  swm_cell_t                  cell_nxt [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      keep;

  // Window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (win_q == '0) begin
      win_eff = CFG_W'(1);
    end else if (win_q > WIN_CLIP) begin
      win_eff = WIN_CLIP;
    end else begin
      win_eff = win_q;
    end
  end

  assign in_i.ready = !res_vld_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  // Broadcast control; the front retires when its age reaches the window
  always_comb begin
    ctrl.step   = step;
    ctrl.clear  = cfg_we_i || (step && in_i.start_req);
    ctrl.shift  = step && !in_i.start_req && cell_st[0].vld &&
                  (cell_st[0].age >= AGE_W'(win_eff));
    ctrl.sample = in_i.sample;
  end

  // Cell chain, front at index zero
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell_t right;
    logic      keep_left;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_st[i+1];
    end

    if (i == 0) begin : g_front
      assign keep_left = 1'b1;
    end else begin : g_back
      assign keep_left = keep[i-1];
    end

    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .right_i     (right),
      .keep_left_i (keep_left),
      .state_o     (cell_st[i]),
      .nxt_o       (cell_nxt[i]),
      .keep_o      (keep[i])
    );
  end

  // Fill count saturates at the window; a result comes once it is full
  always_comb begin
    fill_base = in_i.start_req ? '0 : fill_q;
    fill_d    = (fill_base < AGE_W'(win_eff)) ? fill_base + AGE_W'(1) : fill_base;
    emit      = fill_d >= AGE_W'(win_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_we_i) begin
      fill_q <= '0;
    end else if (step) begin
      fill_q <= fill_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (step) begin
      res_vld_q <= emit;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= cell_nxt[0].val;
    end
  end

  assign out_o.valid      = res_vld_q;
  assign out_o.window_max = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
// One cell of the monotonic candidate queue.
`default_nettype none

module swm_cell import swm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire swm_ctrl_t ctrl_i,
  input  wire swm_cell_t right_i,   // neighbor toward the back of the queue
  input  wire logic      keep_left_i,
  output swm_cell_t      state_o,
  output swm_cell_t      nxt_o,
  output logic           keep_o
);

  logic                       vld_q;
  logic signed [SAMPLE_W-1:0] val_q;
  logic [AGE_W-1:0]           age_q;
  swm_cell_t                  cur;
  swm_cell_t                  nxt;

  assign state_o = '{vld: vld_q, val: val_q, age: age_q};

  // Entry after a possible front retire and sequence clear
  always_comb begin
    cur = ctrl_i.shift ? right_i : state_o;
    if (ctrl_i.clear) begin
      cur.vld = 1'b0;
    end
  end

  // Candidate survives if it is not smaller than the new sample
  assign keep_o = cur.vld && !($signed(cur.val) < $signed(ctrl_i.sample));

  // Keep, take the new sample at the insertion point, or drop
  always_comb begin
    nxt = state_o;
    if (ctrl_i.step) begin
      if (keep_o) begin
        nxt.vld = 1'b1;
        nxt.val = cur.val;
        nxt.age = cur.age + AGE_W'(1);
      end else if (keep_left_i) begin
        nxt.vld = 1'b1;
        nxt.val = ctrl_i.sample;
        nxt.age = AGE_W'(1);
      end else begin
        nxt.vld = 1'b0;
      end
    end else if (ctrl_i.clear) begin
      nxt.vld = 1'b0;
    end
  end

  assign nxt_o = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= nxt.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      val_q <= nxt.val;
      age_q <= nxt.age;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swm_checker.sv =====
// Port-level checks for the sliding window maximum filter, bound to the top.
`default_nettype none

module swm_checker import swm_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic signed [SAMPLE_W-1:0] window_max_i
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(window_max_i))
    else $error("result changed while stalled");

  // A result appears only after a sample beat
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without a sample");

  // An empty output slot always takes samples
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A sample is taken only when the pending result leaves
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i |-> out_ready_i)
    else $error("sample taken over a pending result");

endmodule

bind sliding_window_max_filter swm_checker u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .window_max_i (out_o.window_max)
);

`default_nettype wire

// ===== verif/tb_sliding_window_max_filter.sv =====
// Self-checking testbench for the sliding window maximum filter.
`timescale 1ns / 1ps

module tb_sliding_window_max_filter;
  import swm_pkg::*;

  localparam int WINDOW_MAX  = 64;
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
  localparam int SETTLE_CYC  = 4;     // result shows in the cycle after its input beat

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t S_MAX = 32'sh7fff_ffff;

  // How one directed row is handled
  typedef enum logic [1:0] {
    STEP_WRITE_WIN,   // program the window size with the value column
    STEP_PREDICTED,   // expectation comes from the predictor
    STEP_NO_RESULT,   // window not full yet, nothing comes out
    STEP_KNOWN_MAX    // expectation typed into the table
  } step_kind_e;

  // Value patterns for the random sequences
  typedef enum logic [2:0] {
    SHAPE_RANDOM,
    SHAPE_CLUSTER,    // narrow range, many equal values
    SHAPE_FALLING,    // deepens the candidate store
    SHAPE_RISING,     // keeps flushing the store
    SHAPE_EXTREME
  } shape_e;

  typedef struct {
    step_kind_e kind;
    sample_t    value;
    logic       start;
    sample_t    known_max;
  } dir_step_t;

  logic clk_i;
  logic rst_ni;
  logic             win_we;
  logic [CFG_W-1:0] win_wdata;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_max_filter #(.WINDOW_MAX(WINDOW_MAX)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (win_we),
    .cfg_wdata_i (win_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Window model state
  sample_t          cand_val [$];
  logic [CFG_W-1:0] cand_pos [$];
  logic [CFG_W-1:0] next_pos = '0;
  logic [CFG_W-1:0] fill_cnt = '0;
  logic [CFG_W-1:0] win_reg  = WIN_RESET;

  sample_t expected_max_q [$];
  int      fail_count   = 0;
  int      quiet_cycles = 0;
  int      tx_idle_pct  = 0;
  int      rx_stall_pct = 0;
  int      rx_hold_left = 0;

  // Tag of the beat on offer, read by the monitor at the accepting edge
  step_kind_e beat_kind      = STEP_PREDICTED;
  sample_t    beat_known_max = '0;

  // Directed rows: reset window of 3 first, then windows 0 (acts as 1), 127 and 2
  dir_step_t dir_steps [28] = '{
    '{STEP_NO_RESULT, S_MIN,            1'b0, S_MIN},
    '{STEP_NO_RESULT, S_MIN,            1'b0, S_MIN},
    '{STEP_KNOWN_MAX, S_MAX,            1'b0, S_MAX},
    '{STEP_KNOWN_MAX, 32'sd0,           1'b0, S_MAX},
    '{STEP_KNOWN_MAX, -32'sd1,          1'b0, S_MAX},
    '{STEP_KNOWN_MAX, -32'sd1,          1'b0, 32'sd0},
    '{STEP_KNOWN_MAX, -32'sd1,          1'b0, -32'sd1},
    '{STEP_NO_RESULT, 32'sd5,           1'b1, 32'sd0},
    '{STEP_NO_RESULT, 32'sd7,           1'b0, 32'sd0},
    '{STEP_KNOWN_MAX, 32'sd1,           1'b0, 32'sd7},
    '{STEP_KNOWN_MAX, S_MIN,            1'b0, 32'sd7},
    '{STEP_KNOWN_MAX, S_MIN,            1'b0, 32'sd1},
    '{STEP_KNOWN_MAX, S_MIN,            1'b0, S_MIN},
    '{STEP_PREDICTED, 32'sh5555_5555,   1'b0, 32'sd0},
    '{STEP_PREDICTED, 32'shaaaa_aaaa,   1'b0, 32'sd0},
    '{STEP_WRITE_WIN, 32'sd0,           1'b0, 32'sd0},
    '{STEP_KNOWN_MAX, S_MAX,            1'b0, S_MAX},
    '{STEP_KNOWN_MAX, S_MIN,            1'b1, S_MIN},
    '{STEP_KNOWN_MAX, -32'sd1,          1'b0, -32'sd1},
    '{STEP_WRITE_WIN, 32'sd127,         1'b0, 32'sd0},
    '{STEP_NO_RESULT, 32'sd1,           1'b0, 32'sd0},
    '{STEP_NO_RESULT, 32'sd2,           1'b0, 32'sd0},
    '{STEP_NO_RESULT, 32'sd3,           1'b0, 32'sd0},
    '{STEP_WRITE_WIN, 32'sd2,           1'b0, 32'sd0},
    '{STEP_NO_RESULT, 32'sd10,          1'b0, 32'sd0},
    '{STEP_KNOWN_MAX, 32'sd20,          1'b0, 32'sd20},
    '{STEP_KNOWN_MAX, -32'sd5,          1'b0, 32'sd20},
    '{STEP_KNOWN_MAX, -32'sd6,          1'b0, -32'sd5}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Window maximum after taking one sample; returns 1 when the window is full
  function automatic bit predict_window_max(input sample_t s, input logic start,
                                            output sample_t wmax);
    logic [CFG_W-1:0] w;
    w = (win_reg == '0) ? CFG_W'(1) :
        (win_reg > WINDOW_MAX) ? CFG_W'(WINDOW_MAX) : win_reg;
    if (start) begin
      cand_val.delete();
      cand_pos.delete();
      fill_cnt = '0;
    end
    // retire candidates that slid out of the window
    while (cand_val.size() > 0 && CFG_W'(next_pos - cand_pos[0]) >= w) begin
      cand_val.delete(0);
      cand_pos.delete(0);
    end
    // strictly smaller tail entries can never be the maximum again
    while (cand_val.size() > 0 && cand_val[$] < s) begin
      cand_val.delete(cand_val.size() - 1);
      cand_pos.delete(cand_pos.size() - 1);
    end
    if (cand_val.size() < WINDOW_MAX) begin
      cand_val.insert(cand_val.size(), s);
      cand_pos.insert(cand_pos.size(), next_pos);
    end
    next_pos++;
    if (fill_cnt < w) fill_cnt++;
    wmax = cand_val[0];
    return fill_cnt >= w;
  endfunction

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin : monitor
    sample_t wmax;
    bit      has_max;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      has_max = predict_window_max(in_ch.sample, in_ch.start_req, wmax);
      case (beat_kind)
        STEP_KNOWN_MAX: expected_max_q.insert(expected_max_q.size(), beat_known_max);
        STEP_NO_RESULT: ;
        default: begin
          if (has_max) expected_max_q.insert(expected_max_q.size(), wmax);
        end
      endcase
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_max_q.size() == 0) begin
        $error("window_max: unexpected beat, got %0d", out_ch.window_max);
        fail_count++;
      end else begin
        wmax = expected_max_q[0];
        expected_max_q.delete(0);
        if (out_ch.window_max !== wmax) begin
          $error("window_max mismatch: expected %0d, got %0d", wmax, out_ch.window_max);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one sample beat; returns at the falling edge after it was taken
  task automatic offer_sample(input sample_t s, input logic start,
                              input step_kind_e kind, input sample_t known_max);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= s;
    in_ch.start_req <= start;
    beat_kind       <= kind;
    beat_known_max  <= known_max;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Program the window once the block has drained
  task automatic write_window(input logic [CFG_W-1:0] w);
    in_ch.valid <= 1'b0;
    while (expected_max_q.size() != 0) @(negedge clk_i);
    // a trailing beat with no result may still be in flight
    repeat (SETTLE_CYC) @(negedge clk_i);
    win_we    <= 1'b1;
    win_wdata <= w;
    @(negedge clk_i);
    win_we  <= 1'b0;
    win_reg  = w;
    cand_val.delete();
    cand_pos.delete();
    fill_cnt = '0;
  endtask

  // One random phase: window setting, idling mix, shaped sample runs
  task automatic run_phase(input logic [CFG_W-1:0] w, input int tx_pct, input int rx_pct,
                           input int n_items, input int start_pm, input int hold_at);
    shape_e  shape;
    int      run_left;
    sample_t s;
    logic    start;
    write_window(w);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    run_left     = 0;
    s            = '0;
    shape        = SHAPE_RANDOM;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        shape    = shape_e'($urandom_range(4));
        run_left = $urandom_range(80, 5);
      end
      run_left--;
      case (shape)
        SHAPE_RANDOM:  s = $urandom;
        SHAPE_CLUSTER: s = $signed(32'($urandom_range(8))) - 32'sd4;
        SHAPE_FALLING: s = s - $signed(32'($urandom_range(3)));
        SHAPE_RISING:  s = s + $signed(32'($urandom_range(3)));
        default: begin
          case ($urandom_range(3))
            0:       s = S_MIN;
            1:       s = S_MAX;
            2:       s = 32'sd0;
            default: s = -32'sd1;
          endcase
        end
      endcase
      start = ($urandom_range(999) < start_pm);
      // long receiver hold-off while samples keep coming: the block must back up
      if (i == hold_at) rx_hold_left = 300;
      offer_sample(s, start, STEP_PREDICTED, '0);
    end
  endtask

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    win_we          = 1'b0;
    win_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.start_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, no idling
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_WRITE_WIN)
        write_window(dir_steps[i].value[CFG_W-1:0]);
      else
        offer_sample(dir_steps[i].value, dir_steps[i].start,
                     dir_steps[i].kind, dir_steps[i].known_max);
    end

    // random phases
    run_phase(CFG_W'(4),   0,  0,  60, 30, -1);
    run_phase(CFG_W'(64),  86, 0,  90, 3,  -1);
    run_phase(CFG_W'(1),   0,  86, 60, 50, -1);
    run_phase(CFG_W'(127), 26, 26, 110, 5, -1);
    run_phase(CFG_W'(2),   0,  0,  70, 30, 20);
    run_phase(CFG_W'(96),  0,  0,  80, 0,  -1);  // saturates to the largest window
    run_phase(CFG_W'(17),  86, 0,  50, 20, -1);

    in_ch.valid <= 1'b0;
    while (expected_max_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_max_filter.sv
hw/rtl/swm_checker.sv
verif/tb_sliding_window_max_filter.sv
